FILE: src/tme_pkg.sv
// ----------------------------------------------------------------------------
// tme_pkg
// Shared types and codes for the tape machine instruction executor: status
// codes, command characters and the layout of one request beat.
// ----------------------------------------------------------------------------
package tme_pkg;

   // status codes reported on every response beat
   localparam logic [2:0] ST_RUN   = 3'd0;
   localparam logic [2:0] ST_HALT  = 3'd1;
   localparam logic [2:0] ST_DOVF  = 3'd2;
   localparam logic [2:0] ST_DUNF  = 3'd3;
   localparam logic [2:0] ST_SOVF  = 3'd4;
   localparam logic [2:0] ST_SUNF  = 3'd5;
   localparam logic [2:0] ST_UNBAL = 3'd6;

   // request command field
   localparam logic CMD_EXEC = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // program characters
   localparam logic [7:0] CH_RIGHT = 8'h3E;  // >
   localparam logic [7:0] CH_LEFT  = 8'h3C;  // <
   localparam logic [7:0] CH_INC   = 8'h2B;  // +
   localparam logic [7:0] CH_DEC   = 8'h2D;  // -
   localparam logic [7:0] CH_OUT   = 8'h2E;  // .
   localparam logic [7:0] CH_IN    = 8'h2C;  // ,
   localparam logic [7:0] CH_OPEN  = 8'h5B;  // [
   localparam logic [7:0] CH_CLOSE = 8'h5D;  // ]

   // largest skip nesting count
   localparam logic [15:0] SKIP_MAX = 16'hFFFF;

   // one request beat as held in the execute stage
   typedef struct packed {
      logic        cmd;
      logic [7:0]  prog_byte;
      logic [15:0] prog_pos;
      logic [7:0]  in_byte;
   } tme_item_type;

endpackage

FILE: src/tape_machine_instruction_executor.sv
// ----------------------------------------------------------------------------
// tape_machine_instruction_executor
// Executes one program byte of the eight-command tape language per request
// beat and returns one response beat with the next fetch position, any
// emitted byte and the sticky status.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | cmd, prog_byte, prog_pos, in_byte
//   rsp     | out       | rsp_valid/rsp_stall | next_pos, out_valid, out_byte, status
//
// Each beat passes through a read step that fetches the current tape
// cell and top of stack from the synchronous memories, then an execute
// step that writes back and loads the response register.
// A new request is taken only after the previous beat has left the
// execute stage. After reset the tape is swept to zero; req_stall stays
// high during the sweep.
// A stalled response holds the execute stage; the request side then stalls.
// ----------------------------------------------------------------------------
module tape_machine_instruction_executor
   import tme_pkg::*;
#(
   parameter int TAPE_DEPTH    = 16384,
   parameter int STACK_DEPTH   = 256,
   parameter int PROGRAM_DEPTH = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_prog_byte,
   input  logic [15:0] req_prog_pos,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_next_pos,
   output logic        rsp_out_valid,
   output logic [7:0]  rsp_out_byte,
   output logic [2:0]  rsp_status
);

   localparam int AW  = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
   localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW  = $clog2(STACK_DEPTH + 1);

   // architectural state
   logic [AW-1:0] dp_ff;
   logic [AW-1:0] dp_in;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic [15:0]   skip_ff;
   logic [15:0]   skip_in;
   logic [2:0]    stop_ff;
   logic [2:0]    stop_in;

   // execute stage
   logic          s1_valid_ff;
   logic          s1_valid_in;
   tme_item_type  s1_ff;
   logic          req_fire;
   logic          exec_fire;

   // response register
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [15:0]   rsp_next_pos_ff;
   logic          rsp_out_valid_ff;
   logic [7:0]    rsp_out_byte_ff;
   logic [2:0]    rsp_status_ff;

   // memory ports
   logic [7:0]    tape_rd;
   logic          tape_busy;
   logic          tape_we;
   logic [7:0]    tape_wdata;
   logic [15:0]   stack_top;
   logic          stack_we;
   logic [CW-1:0] cnt_m1;

   // execute results
   logic [15:0]   next_pos;
   logic          out_valid;
   logic [7:0]    out_byte;

   // handshake
   assign req_stall = s1_valid_ff || tape_busy;
   assign req_fire  = req_valid && !req_stall;
   assign exec_fire = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);

   assign s1_valid_in  = req_fire || (s1_valid_ff && !exec_fire);
   assign rsp_valid_in = exec_fire || (rsp_valid_ff && rsp_stall);

   assign cnt_m1 = cnt_ff - CW'(1);

   // memories
   tme_tape #(
      .TAPE_DEPTH (TAPE_DEPTH),
      .AW         (AW)
   ) u_tape (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (dp_ff),
      .rd_data (tape_rd),
      .wr_en   (tape_we),
      .wr_addr (dp_ff),
      .wr_data (tape_wdata),
      .busy    (tape_busy)
   );

   tme_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .SAW         (SAW)
   ) u_stack (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (cnt_m1[SAW-1:0]),
      .rd_data (stack_top),
      .wr_en   (stack_we),
      .wr_addr (cnt_ff[SAW-1:0]),
      .wr_data (s1_ff.prog_pos)
   );

   // instruction execute
   always_comb begin
      dp_in      = dp_ff;
      cnt_in     = cnt_ff;
      skip_in    = skip_ff;
      stop_in    = stop_ff;
      next_pos   = s1_ff.prog_pos + 16'd1;
      out_valid  = 1'b0;
      out_byte   = 8'd0;
      tape_we    = 1'b0;
      tape_wdata = tape_rd;
      stack_we   = 1'b0;

      if (stop_ff == ST_RUN) begin
         if (s1_ff.cmd == CMD_END || s1_ff.prog_pos >= 16'(PROGRAM_DEPTH)) begin
            stop_in = (skip_ff != 16'd0) ? ST_UNBAL : ST_HALT;
         end else if (skip_ff != 16'd0) begin
            // skipping: count bracket nesting only
            if (s1_ff.prog_byte == CH_OPEN) begin
               if (skip_ff != SKIP_MAX) begin
                  skip_in = skip_ff + 16'd1;
               end
            end else if (s1_ff.prog_byte == CH_CLOSE) begin
               skip_in = skip_ff - 16'd1;
            end
         end else begin
            case (s1_ff.prog_byte)
               CH_RIGHT: begin
                  if (dp_ff == AW'(TAPE_DEPTH - 1)) begin
                     stop_in = ST_DOVF;
                  end else begin
                     dp_in = dp_ff + AW'(1);
                  end
               end
               CH_LEFT: begin
                  if (dp_ff == '0) begin
                     stop_in = ST_DUNF;
                  end else begin
                     dp_in = dp_ff - AW'(1);
                  end
               end
               CH_INC: begin
                  tape_we    = 1'b1;
                  tape_wdata = tape_rd + 8'd1;
               end
               CH_DEC: begin
                  tape_we    = 1'b1;
                  tape_wdata = tape_rd - 8'd1;
               end
               CH_OUT: begin
                  out_valid = 1'b1;
                  out_byte  = tape_rd;
               end
               CH_IN: begin
                  tape_we    = 1'b1;
                  tape_wdata = s1_ff.in_byte;
               end
               CH_OPEN: begin
                  if (cnt_ff == CW'(STACK_DEPTH)) begin
                     stop_in = ST_SOVF;
                  end else if (tape_rd != 8'd0) begin
                     stack_we = 1'b1;
                     cnt_in   = cnt_ff + CW'(1);
                  end else begin
                     skip_in = 16'd1;
                  end
               end
               CH_CLOSE: begin
                  if (cnt_ff == '0) begin
                     stop_in = ST_SUNF;
                  end else begin
                     cnt_in = cnt_m1;
                     if (tape_rd != 8'd0) begin
                        next_pos = stack_top;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (stop_in != ST_RUN) begin
         next_pos = s1_ff.prog_pos;
      end

      // writes only land when the beat actually executes
      tape_we  = tape_we && exec_fire;
      stack_we = stack_we && exec_fire;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dp_ff        <= '0;
         cnt_ff       <= '0;
         skip_ff      <= '0;
         stop_ff      <= ST_RUN;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_fire) begin
            dp_ff   <= dp_in;
            cnt_ff  <= cnt_in;
            skip_ff <= skip_in;
            stop_ff <= stop_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff.cmd       <= req_cmd;
         s1_ff.prog_byte <= req_prog_byte;
         s1_ff.prog_pos  <= req_prog_pos;
         s1_ff.in_byte   <= req_in_byte;
      end
      if (exec_fire) begin
         rsp_next_pos_ff  <= next_pos;
         rsp_out_valid_ff <= out_valid;
         rsp_out_byte_ff  <= out_byte;
         rsp_status_ff    <= stop_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_pos  = rsp_next_pos_ff;
   assign rsp_out_valid = rsp_out_valid_ff;
   assign rsp_out_byte  = rsp_out_byte_ff;
   assign rsp_status    = rsp_status_ff;

   // a stop status never changes once raised
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      (stop_ff != ST_RUN) |=> (stop_ff == $past(stop_ff)))
      else $error("stop status changed after a stop");

   // stack fill never passes its depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= CW'(STACK_DEPTH)))
      else $error("stack count beyond depth");

   // data pointer stays on the tape
   a_dp_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, dp_ff} <= (AW + 1)'(TAPE_DEPTH - 1)))
      else $error("data pointer off the tape");

   // no tape write while the clearing sweep runs
   a_no_write_clear: assert property (@(posedge clock) disable iff (reset)
      tape_busy |-> (!tape_we && !s1_valid_ff))
      else $error("tape access during clearing sweep");

   // emitted bytes only on running beats, quiet byte otherwise
   a_out_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_out_valid_ff) |-> (rsp_out_byte_ff == 8'd0))
      else $error("out byte set without out valid");

endmodule

FILE: src/tme_tape.sv
// ----------------------------------------------------------------------------
// tme_tape
// Byte tape memory with one registered read port and one write port. After
// reset it sweeps every cell to zero, one cell a cycle, and flags busy.
// ----------------------------------------------------------------------------
module tme_tape
   import tme_pkg::*;
#(
   parameter int TAPE_DEPTH = 16384,
   parameter int AW         = 14
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   output logic          busy
);

   logic [7:0]    mem [TAPE_DEPTH];
   logic [7:0]    rd_data_ff;
   logic          clearing_ff;
   logic          clearing_in;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;
   logic          clr_last;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;

   // clearing sweep control
   assign clr_last    = (clr_addr_ff == AW'(TAPE_DEPTH - 1));
   assign clearing_in = clearing_ff && !clr_last;
   assign clr_addr_in = clearing_ff ? (clr_addr_ff + AW'(1)) : clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // write port shared by the sweep and the execute stage
   assign mem_we    = clearing_ff || wr_en;
   assign mem_waddr = clearing_ff ? clr_addr_ff : wr_addr;
   assign mem_wdata = clearing_ff ? 8'd0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clearing_ff;

endmodule

FILE: src/tme_stack.sv
// ----------------------------------------------------------------------------
// tme_stack
// Loop-return stack storage: program positions, one registered read port
// and one write port. Contents are undefined until pushed.
// ----------------------------------------------------------------------------
module tme_stack
   import tme_pkg::*;
#(
   parameter int STACK_DEPTH = 256,
   parameter int SAW         = 8
) (
   input  logic           clock,
   input  logic           rd_en,
   input  logic [SAW-1:0] rd_addr,
   output logic [15:0]    rd_data,
   input  logic           wr_en,
   input  logic [SAW-1:0] wr_addr,
   input  logic [15:0]    wr_data
);

   logic [15:0] mem [STACK_DEPTH];
   logic [15:0] rd_data_ff;

   // plain single-port-write, single-port-read storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
